>>> rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types and constants of the bump pointer allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int DefAddrWidth = 32;
    localparam int DataWidth    = 32;
    localparam int CalcWidth    = 36;

    typedef enum logic [2:0] {
        MODE_INIT    = 3'd0,
        MODE_DISPOSE = 3'd1,
        MODE_ALLOC   = 3'd2,
        MODE_ALIGNED = 3'd3,
        MODE_RESIZE  = 3'd4,
        MODE_FREE    = 3'd5,
        MODE_MARK    = 3'd6,
        MODE_RELEASE = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OOM      = 2'd1,
        STATUS_BAD_ALGN = 2'd2,
        STATUS_INACTIVE = 2'd3
    } status_t;

    typedef enum logic {
        CFG_REGION_BASE = 1'b0,
        CFG_REGION_SIZE = 1'b1
    } cfg_index_t;

endpackage

>>> rtl/bump_pointer_allocator.sv
// ----------------------------------------------------------------------------
// bump_pointer_allocator
// request driven bump pointer allocator with mark and release over one region
// ----------------------------------------------------------------------------
// requests enter on the in_valid / in_ready channel, one word per request,
// and every request gives exactly one result word on out_valid / out_ready.
// a request is handled in the cycle it is accepted: pointers are updated at
// that edge and the result sits in the output register from the next cycle,
// and one request per cycle is sustained while the receiver takes results.
// in_ready is high while the output register is empty or being drained in
// the same cycle; a stalled receiver holds the result and stops new requests
// once the output register holds a word, with no word lost.
// region_base and region_size are written through cfg_write / cfg_index / cfg_data;
// the user must write them only while no request is in flight (not enforced by the block);
// the region top is their sum, clipped to the highest word-aligned pointer value.
// reset clears the pointers, the active flag, both region registers and
// the output valid; the allocator answers inactive to all but init and dispose until an init request.
// allocations write a 4-byte size header ahead of the block, reported on the
// header_* outputs; resize that moves a block raises copy_request.
// ----------------------------------------------------------------------------
module bump_pointer_allocator #(
    parameter int ADDR_WIDTH = bpa_pkg::DefAddrWidth
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [bpa_pkg::DataWidth-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     mode,
    input  logic [bpa_pkg::DataWidth-1:0]  request_size,
    input  logic [bpa_pkg::DataWidth-1:0]  alignment,
    input  logic [bpa_pkg::DataWidth-1:0]  address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bpa_pkg::DataWidth-1:0]  result_address,
    output logic [1:0]                     status,
    output logic                           header_write,
    output logic [bpa_pkg::DataWidth-1:0]  header_address,
    output logic [bpa_pkg::DataWidth-1:0]  header_value,
    output logic                           copy_request,
    output logic [bpa_pkg::DataWidth-1:0]  copy_source
);
    import bpa_pkg::*;

    localparam int PW = (ADDR_WIDTH < DataWidth) ? ADDR_WIDTH : DataWidth;
    localparam int W  = CalcWidth;
    localparam logic [W-1:0] PtrMask  = (W'(1) << PW) - W'(1);
    localparam logic [W-1:0] PtrLimit = PtrMask & ~W'(3);

    logic [DataWidth-1:0] region_base_reg;
    logic [DataWidth-1:0] region_size_reg;
    logic [PW-1:0]        next_free_reg, next_free_next;
    logic [PW-1:0]        last_block_reg, last_block_next;
    logic                 active_reg, active_next;

    logic                 out_valid_reg;
    logic [DataWidth-1:0] result_address_reg, result_address_next;
    status_t              status_reg, status_next;
    logic                 header_write_reg, header_write_next;
    logic [DataWidth-1:0] header_address_reg, header_address_next;
    logic [DataWidth-1:0] header_value_reg, header_value_next;
    logic                 copy_request_reg, copy_request_next;
    logic [DataWidth-1:0] copy_source_reg, copy_source_next;

    logic                 accept;
    logic [W-1:0]         nf_w;
    logic [W-1:0]         size_w;
    logic [W-1:0]         top_sum;
    logic [W-1:0]         top_w;
    logic [DataWidth-1:0] align_c;
    logic                 align_bad;
    logic [W-1:0]         plain_caddr;
    logic [W-1:0]         aligned_caddr;
    logic [W-1:0]         caddr;
    logic [W-1:0]         end_w;
    logic [W-1:0]         round_end;
    logic                 fits;
    logic [W-1:0]         inplace_end;
    logic                 inplace_fits;
    logic                 hit;
    logic                 do_place;
    logic                 want_copy;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // operand preparation
    assign nf_w     = W'(next_free_reg);
    assign size_w   = W'(request_size);
    assign top_sum  = W'(region_base_reg) + W'(region_size_reg);
    assign top_w    = (top_sum > PtrLimit) ? PtrLimit : top_sum;
    assign align_c  = (alignment < DataWidth'(4)) ? DataWidth'(4) : alignment;
    assign align_bad = (align_c[1:0] != 2'd0)
                    || ((align_c & (align_c - DataWidth'(1))) != '0);

    // block placement
    assign plain_caddr   = nf_w + W'(4);
    assign aligned_caddr = (nf_w + W'(3) + W'(align_c)) & ~W'(align_c - DataWidth'(1));
    assign caddr         = (mode_t'(mode) == MODE_ALIGNED) ? aligned_caddr : plain_caddr;
    assign end_w         = caddr + size_w;
    assign round_end     = (end_w + W'(3)) & ~W'(3);
    assign fits          = end_w <= top_w;

    // resize in place
    assign hit          = (address != '0) && (address == DataWidth'(last_block_reg));
    assign inplace_end  = W'(address) + size_w;
    assign inplace_fits = inplace_end <= top_w;

    always_comb
    begin
        next_free_next      = next_free_reg;
        last_block_next     = last_block_reg;
        active_next         = active_reg;
        result_address_next = '0;
        status_next         = STATUS_OK;
        header_write_next   = 1'b0;
        header_address_next = '0;
        header_value_next   = '0;
        copy_request_next   = 1'b0;
        copy_source_next    = '0;
        do_place            = 1'b0;
        want_copy           = 1'b0;

        if (mode_t'(mode) == MODE_INIT)
        begin
            next_free_next = PW'(region_base_reg);
            active_next    = 1'b1;
        end
        else if (mode_t'(mode) == MODE_DISPOSE)
        begin
            next_free_next  = '0;
            last_block_next = '0;
            active_next     = 1'b0;
        end
        else if (!active_reg)
        begin
            status_next = STATUS_INACTIVE;
        end
        else
        begin
            case (mode_t'(mode))
                MODE_ALLOC:
                begin
                    do_place = 1'b1;
                end
                MODE_ALIGNED:
                begin
                    if (align_bad)
                    begin
                        status_next = STATUS_BAD_ALGN;
                    end
                    else if (request_size != '0)
                    begin
                        do_place = 1'b1;
                    end
                end
                MODE_RESIZE:
                begin
                    if (hit)
                    begin
                        if (!inplace_fits)
                        begin
                            status_next = STATUS_OOM;
                        end
                        else
                        begin
                            result_address_next = address;
                            header_write_next   = 1'b1;
                            header_address_next = DataWidth'(PW'(address - DataWidth'(4)));
                            header_value_next   = request_size;
                            next_free_next      = PW'(inplace_end);
                        end
                    end
                    else
                    begin
                        do_place  = 1'b1;
                        want_copy = (address != '0);
                    end
                end
                MODE_FREE:
                begin
                    if (hit)
                    begin
                        next_free_next = last_block_reg - PW'(4);
                    end
                end
                MODE_MARK:
                begin
                    result_address_next = DataWidth'(next_free_reg);
                end
                MODE_RELEASE:
                begin
                    next_free_next = PW'(address);
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase

            if (do_place)
            begin
                if (!fits)
                begin
                    status_next = STATUS_OOM;
                end
                else
                begin
                    result_address_next = DataWidth'(PW'(caddr));
                    header_write_next   = 1'b1;
                    header_address_next = DataWidth'(PW'(caddr - W'(4)));
                    header_value_next   = request_size;
                    last_block_next     = PW'(caddr);
                    next_free_next      = PW'(round_end);
                    copy_request_next   = want_copy;
                    copy_source_next    = want_copy ? address : '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
            region_size_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_REGION_BASE: region_base_reg <= cfg_data;
                CFG_REGION_SIZE: region_size_reg <= cfg_data;
                default:         region_base_reg <= region_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg  <= '0;
            last_block_reg <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                next_free_reg  <= next_free_next;
                last_block_reg <= last_block_next;
                active_reg     <= active_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_address_reg <= result_address_next;
            status_reg         <= status_next;
            header_write_reg   <= header_write_next;
            header_address_reg <= header_address_next;
            header_value_reg   <= header_value_next;
            copy_request_reg   <= copy_request_next;
            copy_source_reg    <= copy_source_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_address = result_address_reg;
    assign status         = status_reg;
    assign header_write   = header_write_reg;
    assign header_address = header_address_reg;
    assign header_value   = header_value_reg;
    assign copy_request   = copy_request_reg;
    assign copy_source    = copy_source_reg;

endmodule

>>> rtl/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// port level checks of the bump pointer allocator
// ----------------------------------------------------------------------------
module bpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_address,
    input logic [1:0]  status,
    input logic        header_write,
    input logic [31:0] header_address,
    input logic [31:0] header_value,
    input logic        copy_request
);
    import bpa_pkg::*;

    // an accepted request gives a valid result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request gave no result");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_address)
            && $stable(status) && $stable(header_write))
        else $error("stalled result changed");

    // failure gives null result and no header
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> result_address == '0 && !header_write)
        else $error("failed request reported an allocation");

    // header fields are zero without a header write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !header_write |-> header_address == '0 && header_value == '0)
        else $error("header fields set without header write");

    // a copy only follows a successful new allocation
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && copy_request |-> header_write && status == STATUS_OK
            && result_address != '0)
        else $error("copy request without allocation");

endmodule

bind bump_pointer_allocator bpa_checker u_bpa_checker (.*);
